[src/tof_pair_wall_alignment_profile_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wall alignment turn profile core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOF_PAIR_WALL_ALIGNMENT_PROFILE_CORE_DEFINES_SVH
`define TOF_PAIR_WALL_ALIGNMENT_PROFILE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TPWA_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define TPWA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define TPWA_ASSERT(lbl, ck, rn, prop, msg)
`define TPWA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`endif

`endif

[src/tpwa_pkg.sv]
// ----------------------------------------------------------------------------
// tpwa_pkg
// Widths, codes, command types and helpers for the turn profile core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpwa_pkg;

	localparam int READING_BITS   = 14;
	localparam int RATE_BITS      = 24;
	localparam int TOL_BITS       = 13;
	localparam int GAIN_BITS      = 16;
	localparam int MIN_BITS       = 23;
	localparam int CFG_DATA_BITS  = 23;
	localparam int CFG_INDEX_BITS = 3;

	localparam int DIFF_BITS  = READING_BITS + 1;
	localparam int TWICE_BITS = READING_BITS + 2;
	localparam int CMP_BITS   = ((DIFF_BITS > TOL_BITS + 1) ? DIFF_BITS : TOL_BITS + 1) + 1;
	localparam int MAG_BITS   = (RATE_BITS + 3 > MIN_BITS + 2) ? RATE_BITS + 3 : MIN_BITS + 2;
	localparam int PROD_BITS  = READING_BITS + GAIN_BITS;
	localparam int WIDE_BITS  = (PROD_BITS > RATE_BITS) ? PROD_BITS : RATE_BITS;

	// Division by ten as a multiply by a rounded-up reciprocal.
	localparam int RECIP_SHIFT = RATE_BITS + 3;
	localparam int RECIP_PROD_BITS = 2 * RATE_BITS;
	localparam logic [RATE_BITS-1:0] RECIP_MUL =
		RATE_BITS'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

	localparam logic [TOL_BITS-1:0]  FRONT_TOL_RESET  = TOL_BITS'(10);
	localparam logic [TOL_BITS-1:0]  SIDE_TOL_RESET   = TOL_BITS'(10);
	localparam logic [GAIN_BITS-1:0] FRONT_GAIN_RESET = GAIN_BITS'(66);
	localparam logic [GAIN_BITS-1:0] SIDE_GAIN_RESET  = GAIN_BITS'(328);
	localparam logic [MIN_BITS-1:0]  MIN_SPEED_RESET  = MIN_BITS'(3277);

	localparam logic signed [READING_BITS-1:0] READING_FAIL = READING_BITS'(-100);

	localparam logic signed [MAG_BITS-1:0] RATE_MAX =
		$signed({{(MAG_BITS-RATE_BITS+1){1'b0}}, {(RATE_BITS-1){1'b1}}});
	localparam logic signed [MAG_BITS-1:0] RATE_MIN =
		$signed({{(MAG_BITS-RATE_BITS+1){1'b1}}, {(RATE_BITS-1){1'b0}}});
	localparam logic [WIDE_BITS-1:0] PEAK_MAX =
		{{(WIDE_BITS-RATE_BITS+1){1'b0}}, {(RATE_BITS-1){1'b1}}};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FRONT_TOL  = 3'd0,
		CFG_SIDE_TOL   = 3'd1,
		CFG_FRONT_GAIN = 3'd2,
		CFG_SIDE_GAIN  = 3'd3,
		CFG_MIN_SPEED  = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_ACCEL  = 3'd0,
		PH_CRUISE = 3'd1,
		PH_DECEL  = 3'd2,
		PH_HOLD   = 3'd3,
		PH_STOP   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_PEAK,
		ST_RECIP,
		ST_STEP,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic peak;
		logic recip;
		logic step;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic start_go;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [RATE_BITS-1:0] sat_rate(
		input logic signed [MAG_BITS-1:0] x
	);
		logic signed [MAG_BITS-1:0] y;
		if (x > RATE_MAX) begin
			y = RATE_MAX;
		end else if (x < RATE_MIN) begin
			y = RATE_MIN;
		end else begin
			y = x;
		end
		return y[RATE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

[src/tpwa_item_if.sv]
// ----------------------------------------------------------------------------
// tpwa_item_if
// Request channel: operation, pair select and the two range readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpwa_item_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      operation;
	logic                                      side_select;
	logic signed [tpwa_pkg::READING_BITS-1:0]  reading_a;
	logic signed [tpwa_pkg::READING_BITS-1:0]  reading_b;

	modport source (
		output valid, operation, side_select, reading_a, reading_b,
		input  ready
	);
	modport sink (
		input  valid, operation, side_select, reading_a, reading_b,
		output ready
	);
endinterface

`default_nettype wire

[src/tpwa_result_if.sv]
// ----------------------------------------------------------------------------
// tpwa_result_if
// Result channel: turn rate command, status flags and the final reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpwa_result_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [tpwa_pkg::RATE_BITS-1:0]     turn_rate;
	logic                                      command_valid;
	logic                                      range_error;
	logic                                      done_res;
	logic signed [tpwa_pkg::READING_BITS-1:0]  final_reading;

	modport source (
		output valid, turn_rate, command_valid, range_error, done_res, final_reading,
		input  ready
	);
	modport sink (
		input  valid, turn_rate, command_valid, range_error, done_res, final_reading,
		output ready
	);
endinterface

`default_nettype wire

[src/tpwa_ctrl.sv]
// ----------------------------------------------------------------------------
// tpwa_ctrl
// Sequencer: accepts a request, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tof_pair_wall_alignment_profile_core_defines.svh"

module tpwa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire tpwa_pkg::dp_status_t status,
	output tpwa_pkg::dp_cmd_t         cmd
);

	tpwa_pkg::state_t state_q;
	tpwa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			tpwa_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = tpwa_pkg::ST_EVAL;
				end
			end
			tpwa_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.start_go ? tpwa_pkg::ST_MUL : tpwa_pkg::ST_PUSH;
			end
			tpwa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = tpwa_pkg::ST_PEAK;
			end
			tpwa_pkg::ST_PEAK: begin
				cmd.peak = 1'b1;
				state_d  = tpwa_pkg::ST_RECIP;
			end
			tpwa_pkg::ST_RECIP: begin
				cmd.recip = 1'b1;
				state_d   = tpwa_pkg::ST_STEP;
			end
			tpwa_pkg::ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = tpwa_pkg::ST_PUSH;
			end
			tpwa_pkg::ST_PUSH: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = tpwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpwa_pkg::ST_IDLE;
			end
		endcase
	end

	`TPWA_ASSERT_IMPL(a_eval_after_idle, clk, arst_n, state_q == tpwa_pkg::ST_EVAL, $past(state_q) == tpwa_pkg::ST_IDLE, "evaluation without an accepted request")
	`TPWA_ASSERT_IMPL(a_push_entry, clk, arst_n, state_q == tpwa_pkg::ST_PUSH, $past(state_q) == tpwa_pkg::ST_EVAL || $past(state_q) == tpwa_pkg::ST_STEP || $past(state_q) == tpwa_pkg::ST_PUSH, "result hand-off entered out of sequence")

endmodule

`default_nettype wire

[src/tpwa_datapath.sv]
// ----------------------------------------------------------------------------
// tpwa_datapath
// Configuration, alignment state, phase evaluation, peak and step arithmetic
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tof_pair_wall_alignment_profile_core_defines.svh"

module tpwa_datapath (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire tpwa_pkg::dp_cmd_t                        cmd,
	output tpwa_pkg::dp_status_t                          status,
	input  wire logic                                     cfg_write,
	input  wire logic [tpwa_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  wire logic [tpwa_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  wire logic                                     operation,
	input  wire logic                                     side_select,
	input  wire logic signed [tpwa_pkg::READING_BITS-1:0] reading_a,
	input  wire logic signed [tpwa_pkg::READING_BITS-1:0] reading_b,
	input  wire logic                                     result_ready,
	output logic                                          result_valid,
	output logic signed [tpwa_pkg::RATE_BITS-1:0]         turn_rate,
	output logic                                          command_valid,
	output logic                                          range_error,
	output logic                                          done_res,
	output logic signed [tpwa_pkg::READING_BITS-1:0]      final_reading
);

	localparam int RB = tpwa_pkg::READING_BITS;
	localparam int RT = tpwa_pkg::RATE_BITS;
	localparam int MB = tpwa_pkg::MAG_BITS;
	localparam int CB = tpwa_pkg::CMP_BITS;
	localparam int DB = tpwa_pkg::DIFF_BITS;
	localparam int TB = tpwa_pkg::TWICE_BITS;

	logic [tpwa_pkg::TOL_BITS-1:0]  front_tol_q;
	logic [tpwa_pkg::TOL_BITS-1:0]  side_tol_q;
	logic [tpwa_pkg::GAIN_BITS-1:0] front_gain_q;
	logic [tpwa_pkg::GAIN_BITS-1:0] side_gain_q;
	logic [tpwa_pkg::MIN_BITS-1:0]  min_speed_q;

	logic                   op_q;
	logic                   side_q;
	logic signed [RB-1:0]   a_q;
	logic signed [RB-1:0]   b_q;

	logic                   active_q;
	tpwa_pkg::phase_t       phase_q;
	logic                   turn_pos_q;
	logic                   use_side_q;
	logic [RB-1:0]          gap_q;
	logic [RT-1:0]          peak_q;
	logic [RT-1:0]          step_q;
	logic signed [RT-1:0]   rate_q;

	logic [tpwa_pkg::PROD_BITS-1:0]       prod_q;
	logic [tpwa_pkg::RECIP_PROD_BITS-1:0] recip_q;

	logic                   pend_valid_q;
	logic                   pend_rerr_q;
	logic                   pend_done_q;
	logic signed [RT-1:0]   pend_rate_q;
	logic signed [RB-1:0]   pend_final_q;

	logic                   out_valid_q;
	logic signed [RT-1:0]   out_rate_q;
	logic                   out_cmd_q;
	logic                   out_rerr_q;
	logic                   out_done_q;
	logic signed [RB-1:0]   out_final_q;

	// Shared evaluation terms.
	logic signed [DB-1:0]   diff_w;
	logic                   is_fail;
	logic [tpwa_pkg::TOL_BITS-1:0] tol_start;
	logic [tpwa_pkg::TOL_BITS-1:0] tol_tick;
	logic signed [CB-1:0]   diff_c;
	logic signed [CB-1:0]   tol_start_c;
	logic                   in_tol;
	logic signed [DB-1:0]   abs_w;
	logic signed [DB-1:0]   e_w;
	logic signed [TB-1:0]   two_e;
	logic signed [TB-1:0]   gap_c;
	logic signed [CB-1:0]   e_c;
	logic signed [CB-1:0]   tol_tick_c;
	logic                   e_gt_tol;
	logic signed [MB-1:0]   rate_m;
	logic signed [MB-1:0]   m_w;
	logic signed [MB-1:0]   peak_m;
	logic signed [MB-1:0]   step_m;
	logic signed [MB-1:0]   min_m;
	logic                   c_acc;
	logic                   c_cru;
	logic                   c_dec;
	logic                   c_hold;
	logic                   is_stop;
	tpwa_pkg::phase_t       phase_n;
	logic signed [MB-1:0]   m_n;
	logic signed [RT-1:0]   rate_n;
	logic [tpwa_pkg::GAIN_BITS-1:0] gain_w;
	logic [tpwa_pkg::WIDE_BITS-1:0] prod_wide;

	always_comb begin
		diff_w      = DB'(a_q) - DB'(b_q);
		is_fail     = (a_q == tpwa_pkg::READING_FAIL) || (b_q == tpwa_pkg::READING_FAIL);
		tol_start   = side_q ? side_tol_q : front_tol_q;
		tol_tick    = use_side_q ? side_tol_q : front_tol_q;
		diff_c      = CB'(diff_w);
		tol_start_c = $signed(CB'(tol_start));
		in_tol      = (diff_c <= tol_start_c) && (diff_c >= -tol_start_c);
		abs_w       = diff_w[DB-1] ? -diff_w : diff_w;

		e_w        = turn_pos_q ? diff_w : -diff_w;
		two_e      = $signed({e_w, 1'b0});
		gap_c      = $signed(TB'(gap_q));
		e_c        = CB'(e_w);
		tol_tick_c = $signed(CB'(tol_tick));
		e_gt_tol   = e_c > tol_tick_c;

		rate_m = MB'(rate_q);
		m_w    = turn_pos_q ? rate_m : -rate_m;
		peak_m = $signed(MB'(peak_q));
		step_m = $signed(MB'(step_q));
		min_m  = $signed(MB'(min_speed_q));

		c_acc  = (phase_q == tpwa_pkg::PH_ACCEL) && (two_e > gap_c) && (m_w <= peak_m);
		c_cru  = (phase_q <= tpwa_pkg::PH_CRUISE) && (two_e > gap_c);
		c_dec  = (phase_q <= tpwa_pkg::PH_DECEL) && (two_e < gap_c) && e_gt_tol && (m_w > min_m);
		c_hold = (phase_q <= tpwa_pkg::PH_HOLD) && e_gt_tol;

		is_stop = 1'b0;
		phase_n = tpwa_pkg::PH_ACCEL;
		m_n     = '0;
		if (c_acc) begin
			phase_n = tpwa_pkg::PH_ACCEL;
			m_n     = m_w + step_m;
		end else if (c_cru) begin
			phase_n = tpwa_pkg::PH_CRUISE;
			m_n     = peak_m;
		end else if (c_dec) begin
			phase_n = tpwa_pkg::PH_DECEL;
			m_n     = m_w - step_m;
		end else if (c_hold) begin
			phase_n = tpwa_pkg::PH_HOLD;
			m_n     = min_m;
		end else begin
			is_stop = 1'b1;
		end
		rate_n = tpwa_pkg::sat_rate(turn_pos_q ? m_n : -m_n);

		gain_w    = use_side_q ? side_gain_q : front_gain_q;
		prod_wide = tpwa_pkg::WIDE_BITS'(prod_q);
	end

	assign status.start_go = op_q && !is_fail && !in_tol;
	assign status.out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_tol_q  <= tpwa_pkg::FRONT_TOL_RESET;
			side_tol_q   <= tpwa_pkg::SIDE_TOL_RESET;
			front_gain_q <= tpwa_pkg::FRONT_GAIN_RESET;
			side_gain_q  <= tpwa_pkg::SIDE_GAIN_RESET;
			min_speed_q  <= tpwa_pkg::MIN_SPEED_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tpwa_pkg::CFG_FRONT_TOL:  front_tol_q  <= cfg_data[tpwa_pkg::TOL_BITS-1:0];
				tpwa_pkg::CFG_SIDE_TOL:   side_tol_q   <= cfg_data[tpwa_pkg::TOL_BITS-1:0];
				tpwa_pkg::CFG_FRONT_GAIN: front_gain_q <= cfg_data[tpwa_pkg::GAIN_BITS-1:0];
				tpwa_pkg::CFG_SIDE_GAIN:  side_gain_q  <= cfg_data[tpwa_pkg::GAIN_BITS-1:0];
				tpwa_pkg::CFG_MIN_SPEED:  min_speed_q  <= cfg_data[tpwa_pkg::MIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			side_q <= side_select;
			a_q    <= reading_a;
			b_q    <= reading_b;
		end
		if (cmd.mul) begin
			prod_q <= gap_q * gain_w;
		end
		if (cmd.recip) begin
			recip_q <= tpwa_pkg::RECIP_PROD_BITS'(peak_q)
				* tpwa_pkg::RECIP_PROD_BITS'(tpwa_pkg::RECIP_MUL);
		end
		if (cmd.eval) begin
			pend_valid_q <= !op_q && active_q;
			pend_rerr_q  <= op_q && is_fail;
			pend_done_q  <= op_q ? (!is_fail && in_tol) : (active_q && is_stop);
			pend_rate_q  <= (!op_q && active_q && !is_stop) ? rate_n : '0;
			pend_final_q <= (op_q && !is_fail && in_tol) ? a_q
				: ((!op_q && active_q && is_stop) ? (turn_pos_q ? b_q : a_q) : '0);
		end
		if (cmd.push) begin
			out_rate_q  <= pend_rate_q;
			out_cmd_q   <= pend_valid_q;
			out_rerr_q  <= pend_rerr_q;
			out_done_q  <= pend_done_q;
			out_final_q <= pend_final_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			phase_q    <= tpwa_pkg::PH_ACCEL;
			turn_pos_q <= 1'b0;
			use_side_q <= 1'b0;
			gap_q      <= '0;
			peak_q     <= '0;
			step_q     <= '0;
			rate_q     <= '0;
		end else begin
			if (cmd.eval) begin
				if (op_q) begin
					if (!is_fail && in_tol) begin
						active_q <= 1'b0;
						phase_q  <= tpwa_pkg::PH_ACCEL;
					end else if (!is_fail) begin
						use_side_q <= side_q;
						turn_pos_q <= diff_w > 0;
						gap_q      <= abs_w[RB-1:0];
						rate_q     <= '0;
						phase_q    <= tpwa_pkg::PH_ACCEL;
						active_q   <= 1'b1;
					end
				end else if (active_q) begin
					if (is_stop) begin
						rate_q   <= '0;
						active_q <= 1'b0;
						phase_q  <= tpwa_pkg::PH_ACCEL;
					end else begin
						rate_q  <= rate_n;
						phase_q <= phase_n;
					end
				end
			end
			if (cmd.peak) begin
				peak_q <= (prod_wide > tpwa_pkg::PEAK_MAX) ? tpwa_pkg::PEAK_MAX[RT-1:0]
					: prod_wide[RT-1:0];
			end
			if (cmd.step) begin
				step_q <= RT'(recip_q >> tpwa_pkg::RECIP_SHIFT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid  = out_valid_q;
	assign turn_rate     = out_rate_q;
	assign command_valid = out_cmd_q;
	assign range_error   = out_rerr_q;
	assign done_res      = out_done_q;
	assign final_reading = out_final_q;

	`TPWA_ASSERT_IMPL(a_push_when_free, clk, arst_n, cmd.push, status.out_free, "result overwrote a waiting result")
	`TPWA_ASSERT(a_phase_not_stop, clk, arst_n, phase_q != tpwa_pkg::PH_STOP, "stop phase left in the phase register")
	`TPWA_ASSERT_IMPL(a_step_after_recip, clk, arst_n, cmd.step, $past(cmd.recip), "step taken without a fresh reciprocal product")

endmodule

`default_nettype wire

[src/tof_pair_wall_alignment_profile_core.sv]
// A tick, a rejected start or a start within tolerance goes from acceptance through
// evaluation straight to the result hand-off; a start that begins a turn also steps
// through the gain multiply, peak clamp, divide-by-ten reciprocal multiply and step
// stages. A new request is taken only once the sequencer is back in idle.
// A waiting result does not block acceptance; only its hand-off waits for the sink.
// Reset clears the sequencer and alignment state and loads the register defaults.
// ----------------------------------------------------------------------------
// tof_pair_wall_alignment_profile_core
// Wall alignment turn profile for a pair of range sensors.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_pair_wall_alignment_profile_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	tpwa_item_if.sink                                 item,
	tpwa_result_if.source                             result,
	input  wire logic                                 cfg_write,
	input  wire logic [tpwa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [tpwa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	tpwa_pkg::dp_cmd_t    cmd;
	tpwa_pkg::dp_status_t status;
	logic                 item_ready;

	tpwa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	tpwa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (item.operation),
		.side_select   (item.side_select),
		.reading_a     (item.reading_a),
		.reading_b     (item.reading_b),
		.result_ready  (result.ready),
		.result_valid  (result.valid),
		.turn_rate     (result.turn_rate),
		.command_valid (result.command_valid),
		.range_error   (result.range_error),
		.done_res      (result.done_res),
		.final_reading (result.final_reading)
	);

	assign item.ready = item_ready;

endmodule

`default_nettype wire
